@@ hw/rtl/lts_pkg.sv @@
package lts_pkg;

   // Operand and intermediate widths.
   localparam int CW   = 32;          // coordinate and conductivity width
   localparam int DW   = CW + 1;      // vertex difference width, signed
   localparam int PW   = 2 * DW;      // product of two differences, signed
   localparam int SW   = PW + 1;      // determinant and numerator width, signed
   localparam int AW   = SW - 1;      // magnitude of determinant or numerator
   localparam int HW   = AW - DW;     // upper slice of a magnitude
   localparam int PPW  = CW + DW;     // partial product of conductivity and a slice
   localparam int MW   = CW + AW;     // full product of conductivity and a magnitude
   localparam int DENW = AW + 1;      // divisor, twice the absolute determinant
   localparam int QW   = 32;          // quotient and result width
   localparam int TW   = 16;          // tag width
   localparam int NE   = 6;           // unique matrix entries

   localparam int DIV_STAGES = 16;
   localparam int DIV_STEPS  = QW / DIV_STAGES;

   // Stage positions of the whole pipeline.
   localparam int ST_DIV = 8;
   localparam int NS     = ST_DIV + DIV_STAGES + 1;

   // Row and column of each unique entry.
   localparam int PI [NE] = '{0, 0, 0, 1, 1, 2};
   localparam int PJ [NE] = '{0, 1, 2, 1, 2, 2};

   typedef struct packed {
      logic [DENW-1:0] rem;
      logic [QW-1:0]   nq;
   } lts_div_type;

   // One restoring division step: the numerator bits shift out of nq while the
   // quotient bits shift in.
   function automatic lts_div_type lts_step(lts_div_type s, logic [DENW-1:0] den);
      logic [DENW:0] t;
      logic          ge;
      lts_div_type   r;
      t  = {s.rem, s.nq[QW-1]};
      ge = (t >= {1'b0, den});
      if (ge) begin
         t = t - {1'b0, den};
      end
      r.rem = t[DENW-1:0];
      r.nq  = {s.nq[QW-2:0], ge};
      return r;
   endfunction

endpackage

@@ hw/rtl/linear_triangle_stiffness.sv @@
// Stiffness matrix of a linear triangle, fully pipelined.
// Accepts one triangle per cycle unless the response side stalls; the pipeline
// holds up to 25 triangles and squeezes out bubbles while the response stalls.
// Reset clears the valid bits of every stage; the data registers are not reset.
module linear_triangle_stiffness (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [15:0]            req_element_tag,
   input  logic signed [31:0]     req_x0,
   input  logic signed [31:0]     req_y0,
   input  logic signed [31:0]     req_x1,
   input  logic signed [31:0]     req_y1,
   input  logic signed [31:0]     req_x2,
   input  logic signed [31:0]     req_y2,
   input  logic [31:0]            req_conductivity,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_result_tag,
   output logic signed [31:0]     rsp_g00,
   output logic signed [31:0]     rsp_g01,
   output logic signed [31:0]     rsp_g02,
   output logic signed [31:0]     rsp_g11,
   output logic signed [31:0]     rsp_g12,
   output logic signed [31:0]     rsp_g22,
   output logic                   rsp_degenerate,
   output logic                   rsp_saturated
);
   import lts_pkg::*;

   // Side data that rides along with the divider stages.
   typedef struct packed {
      logic [TW-1:0] tag;
      logic          zero;
      logic [NE-1:0] neg;
      logic [NE-1:0] ovf;
   } side_type;

   // Each stage takes a new beat when it is empty or when its contents move on.
   // The chain starts at the response port, so a stall only stops the stages
   // that actually hold data.
   logic [NS-1:0] v_ff;
   logic [NS-1:0] load;

   always_comb begin
      load[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS-2; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (load[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Stage 1: edge vectors. b_i = y_j - y_k and c_i = x_k - x_j, cyclic.
   logic signed [DW-1:0] b_ff [3];
   logic signed [DW-1:0] c_ff [3];
   logic [CW-1:0]        lam1_ff;
   logic [TW-1:0]        tag1_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         b_ff[0] <= $signed({req_y1[31], req_y1}) - $signed({req_y2[31], req_y2});
         b_ff[1] <= $signed({req_y2[31], req_y2}) - $signed({req_y0[31], req_y0});
         b_ff[2] <= $signed({req_y0[31], req_y0}) - $signed({req_y1[31], req_y1});
         c_ff[0] <= $signed({req_x2[31], req_x2}) - $signed({req_x1[31], req_x1});
         c_ff[1] <= $signed({req_x0[31], req_x0}) - $signed({req_x2[31], req_x2});
         c_ff[2] <= $signed({req_x1[31], req_x1}) - $signed({req_x0[31], req_x0});
         lam1_ff <= req_conductivity;
         tag1_ff <= req_element_tag;
      end
   end

   // Stage 2: all products. The determinant is c2*b1 - c1*b2, since
   // x1-x0 = c2, y2-y0 = b1, x2-x0 = -c1 and y1-y0 = -b2.
   logic signed [PW-1:0] pd1_ff, pd2_ff;
   logic signed [PW-1:0] pb_ff [NE];
   logic signed [PW-1:0] pc_ff [NE];
   logic [CW-1:0]        lam2_ff;
   logic [TW-1:0]        tag2_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         pd1_ff <= c_ff[2] * b_ff[1];
         pd2_ff <= c_ff[1] * b_ff[2];
         for (int e = 0; e < NE; e++) begin
            pb_ff[e] <= b_ff[PI[e]] * b_ff[PJ[e]];
            pc_ff[e] <= c_ff[PI[e]] * c_ff[PJ[e]];
         end
         lam2_ff <= lam1_ff;
         tag2_ff <= tag1_ff;
      end
   end

   // Stage 3: determinant and entry numerators, exact.
   logic signed [SW-1:0] d_ff;
   logic signed [SW-1:0] num_ff [NE];
   logic [CW-1:0]        lam3_ff;
   logic [TW-1:0]        tag3_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         d_ff <= $signed({pd1_ff[PW-1], pd1_ff}) - $signed({pd2_ff[PW-1], pd2_ff});
         for (int e = 0; e < NE; e++) begin
            num_ff[e] <= $signed({pb_ff[e][PW-1], pb_ff[e]})
                       + $signed({pc_ff[e][PW-1], pc_ff[e]});
         end
         lam3_ff <= lam2_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // Stage 4: magnitudes and signs.
   logic [AW-1:0] absd4_ff;
   logic          zero4_ff;
   logic [NE-1:0] neg4_ff;
   logic [AW-1:0] mnum_ff [NE];
   logic [CW-1:0] lam4_ff;
   logic [TW-1:0] tag4_ff;
   logic [SW-1:0] negd;
   logic [SW-1:0] negn [NE];

   always_comb begin
      negd = -d_ff;
      for (int e = 0; e < NE; e++) begin
         negn[e] = -num_ff[e];
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         absd4_ff <= d_ff[SW-1] ? negd[AW-1:0] : d_ff[AW-1:0];
         zero4_ff <= (d_ff == '0);
         for (int e = 0; e < NE; e++) begin
            neg4_ff[e] <= num_ff[e][SW-1];
            mnum_ff[e] <= num_ff[e][SW-1] ? negn[e][AW-1:0] : num_ff[e][AW-1:0];
         end
         lam4_ff <= lam3_ff;
         tag4_ff <= tag3_ff;
      end
   end

   // Stage 5: conductivity times each numerator, as two partial products.
   logic [PPW-1:0] plo_ff [NE];
   logic [PPW-1:0] phi_ff [NE];
   logic [AW-1:0]  absd5_ff;
   logic           zero5_ff;
   logic [NE-1:0]  neg5_ff;
   logic [TW-1:0]  tag5_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         for (int e = 0; e < NE; e++) begin
            plo_ff[e] <= lam4_ff * mnum_ff[e][DW-1:0];
            phi_ff[e] <= lam4_ff * {1'b0, mnum_ff[e][AW-1:DW]};
         end
         absd5_ff <= absd4_ff;
         zero5_ff <= zero4_ff;
         neg5_ff  <= neg4_ff;
         tag5_ff  <= tag4_ff;
      end
   end

   // Stage 6: combine the partial products.
   logic [MW-1:0] mag_ff [NE];
   logic [AW-1:0] absd6_ff;
   logic          zero6_ff;
   logic [NE-1:0] neg6_ff;
   logic [TW-1:0] tag6_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         for (int e = 0; e < NE; e++) begin
            mag_ff[e] <= {{(MW-PPW){1'b0}}, plo_ff[e]}
                       + {phi_ff[e][MW-DW-1:0], {DW{1'b0}}};
         end
         absd6_ff <= absd5_ff;
         zero6_ff <= zero5_ff;
         neg6_ff  <= neg5_ff;
         tag6_ff  <= tag5_ff;
      end
   end

   // Stage 7: rounding bias. round(m / 2|D|) = floor((m + |D|) / 2|D|).
   logic [MW-1:0]   n7_ff [NE];
   logic [DENW-1:0] den7_ff;
   logic            zero7_ff;
   logic [NE-1:0]   neg7_ff;
   logic [TW-1:0]   tag7_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         for (int e = 0; e < NE; e++) begin
            n7_ff[e] <= mag_ff[e] + {{(MW-AW){1'b0}}, absd6_ff};
         end
         den7_ff  <= {absd6_ff, 1'b0};
         zero7_ff <= zero6_ff;
         neg7_ff  <= neg6_ff;
         tag7_ff  <= tag6_ff;
      end
   end

   // Stage 8: a quotient of 2^32 or more saturates whatever its sign, so the
   // divider only has to produce 32 quotient bits.
   logic [MW-1:0]   n8_ff [NE];
   logic [DENW-1:0] den8_ff;
   side_type        side8_ff;

   always_ff @(posedge clock) begin
      if (load[7]) begin
         for (int e = 0; e < NE; e++) begin
            n8_ff[e]           <= n7_ff[e];
            side8_ff.ovf[e]    <= ({1'b0, n7_ff[e]} >= {den7_ff, {QW{1'b0}}});
         end
         den8_ff       <= den7_ff;
         side8_ff.tag  <= tag7_ff;
         side8_ff.zero <= zero7_ff;
         side8_ff.neg  <= neg7_ff;
      end
   end

   // Stages 9 to 24: one restoring divider per entry, two quotient bits per
   // stage, with the side data in a matching delay line.
   logic [QW-1:0] q [NE];
   side_type      side_ff [DIV_STAGES];

   for (genvar e = 0; e < NE; e++) begin : g_div
      lts_div u_div (
         .clock  (clock),
         .load   (load[ST_DIV +: DIV_STAGES]),
         .n_in   (n8_ff[e]),
         .den_in (den8_ff),
         .q_out  (q[e])
      );
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (load[ST_DIV + k]) begin
            side_ff[k] <= (k == 0) ? side8_ff : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // Stage 25: sign, saturation and the degenerate case into the output register.
   side_type      sd;
   logic [QW-1:0] val_in [NE];
   logic [NE-1:0] sat_in;
   logic [QW-1:0] g_ff [NE];
   logic [TW-1:0] tag_ff;
   logic          deg_ff, sat_ff;

   always_comb begin
      logic [QW-1:0] lim;
      sd = side_ff[DIV_STAGES-1];
      for (int e = 0; e < NE; e++) begin
         lim = sd.neg[e] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
         sat_in[e] = sd.ovf[e] || (q[e] > lim);
         if (sd.zero) begin
            val_in[e] = '0;
         end else if (sat_in[e]) begin
            val_in[e] = lim;
         end else begin
            val_in[e] = sd.neg[e] ? -q[e] : q[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[NS-1]) begin
         for (int e = 0; e < NE; e++) begin
            g_ff[e] <= val_in[e];
         end
         tag_ff <= sd.tag;
         deg_ff <= sd.zero;
         sat_ff <= !sd.zero && (|sat_in);
      end
   end

   assign rsp_result_tag = tag_ff;
   assign rsp_g00        = g_ff[0];
   assign rsp_g01        = g_ff[1];
   assign rsp_g02        = g_ff[2];
   assign rsp_g11        = g_ff[3];
   assign rsp_g12        = g_ff[4];
   assign rsp_g22        = g_ff[5];
   assign rsp_degenerate = deg_ff;
   assign rsp_saturated  = sat_ff;

endmodule

@@ hw/rtl/lts_div.sv @@
module lts_div (
   input  logic                        clock,
   input  logic [lts_pkg::DIV_STAGES-1:0] load,
   input  logic [lts_pkg::MW-1:0]      n_in,
   input  logic [lts_pkg::DENW-1:0]    den_in,
   output logic [lts_pkg::QW-1:0]      q_out
);
   import lts_pkg::*;

   lts_div_type     st_ff  [DIV_STAGES];
   logic [DENW-1:0] den_ff [DIV_STAGES];
   lts_div_type     st_in  [DIV_STAGES];

   always_comb begin
      lts_div_type s;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            s.rem = {1'b0, n_in[MW-1:QW]};
            s.nq  = n_in[QW-1:0];
         end else begin
            s = st_ff[(k == 0) ? 0 : k-1];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            s = lts_step(s, (k == 0) ? den_in : den_ff[(k == 0) ? 0 : k-1]);
         end
         st_in[k] = s;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (load[k]) begin
            st_ff[k]  <= st_in[k];
            den_ff[k] <= (k == 0) ? den_in : den_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign q_out = st_ff[DIV_STAGES-1].nq;

endmodule

@@ tb/linear_triangle_stiffness_test.sv @@
`timescale 1ns / 1ps

// One expected or observed response beat.
typedef struct {
   logic [15:0]        tag;
   logic signed [31:0] g [6];
   logic               degenerate;
   logic               saturated;
} element_result_type;

// Holds the stiffness entries that each accepted triangle should produce and
// compares every response beat against the oldest one still outstanding.
class stiffness_scoreboard;
   element_result_type pending[$];
   int                 mismatches;
   int                 checked;
   int                 degenerate_seen;
   int                 saturated_seen;

   // Rounded quotient lambda*|num| / (2|D|), clipped to the signed 32-bit range.
   static function logic [31:0] entry_value(logic [31:0] lambda, logic signed [127:0] num,
                                            logic [127:0] absd, inout logic sat);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] q;
      logic [127:0] limit;
      neg   = num < 0;
      mag   = lambda * (neg ? -num : num);
      q     = (mag + absd) / (absd + absd);
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) begin
         sat = 1'b1;
         return limit[31:0];
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   function void note_triangle(logic [15:0] tag, logic signed [31:0] vx [3],
                               logic signed [31:0] vy [3], logic [31:0] lambda);
      element_result_type  r;
      logic signed [127:0] x [3];
      logic signed [127:0] y [3];
      logic signed [127:0] b [3];
      logic signed [127:0] c [3];
      logic signed [127:0] det;
      logic [127:0]        absd;
      int                  ri [6] = '{0, 0, 0, 1, 1, 2};
      int                  ci [6] = '{0, 1, 2, 1, 2, 2};
      for (int i = 0; i < 3; i++) begin
         x[i] = vx[i];
         y[i] = vy[i];
      end
      r.tag        = tag;
      r.degenerate = 1'b0;
      r.saturated  = 1'b0;
      det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
      if (det == 0) begin
         foreach (r.g[e]) r.g[e] = '0;
         r.degenerate = 1'b1;
      end else begin
         absd = det < 0 ? -det : det;
         b[0] = y[1] - y[2]; b[1] = y[2] - y[0]; b[2] = y[0] - y[1];
         c[0] = x[2] - x[1]; c[1] = x[0] - x[2]; c[2] = x[1] - x[0];
         for (int e = 0; e < 6; e++)
            r.g[e] = entry_value(lambda, b[ri[e]] * b[ci[e]] + c[ri[e]] * c[ci[e]],
                                 absd, r.saturated);
      end
      pending = {pending, r};
   endfunction

   function void check_result(element_result_type got);
      element_result_type want;
      logic               bad;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response beat, tag %0h", got.tag);
         return;
      end
      want = pending.pop_front();
      bad  = (got.tag !== want.tag) || (got.degenerate !== want.degenerate)
          || (got.saturated !== want.saturated);
      foreach (want.g[e]) if (got.g[e] !== want.g[e]) bad = 1'b1;
      if (want.degenerate) degenerate_seen++;
      if (want.saturated) saturated_seen++;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch tag %0h: expected g=%p deg=%b sat=%b, got tag %0h g=%p deg=%b sat=%b",
                     want.tag, want.g, want.degenerate, want.saturated,
                     got.tag, got.g, got.degenerate, got.saturated);
      end
   endfunction
endclass

module linear_triangle_stiffness_test;

   localparam int RANDOM_TRIANGLES = 1880;
   localparam int PIPE_LATENCY     = 25;
   localparam longint CYCLE_LIMIT  = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_element_tag = '0;
   logic signed [31:0] req_x0 = '0, req_y0 = '0, req_x1 = '0, req_y1 = '0;
   logic signed [31:0] req_x2 = '0, req_y2 = '0;
   logic [31:0]        req_conductivity = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_result_tag;
   logic signed [31:0] rsp_g00, rsp_g01, rsp_g02, rsp_g11, rsp_g12, rsp_g22;
   logic               rsp_degenerate;
   logic               rsp_saturated;

   stiffness_scoreboard stiffness_check = new();
   longint              cycle_count = 0;
   int                  triangles_sent = 0;
   // The responder honors these; the long hold-off is what fills the pipeline.
   logic                quiet_phase = 1'b0;
   int                  holdoff_cycles = 0;

   linear_triangle_stiffness u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: any hang ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response beats are sampled at the rising edge and compared in order.
   always @(posedge clock) begin
      element_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.tag        = rsp_result_tag;
         got.g          = '{rsp_g00, rsp_g01, rsp_g02, rsp_g11, rsp_g12, rsp_g22};
         got.degenerate = rsp_degenerate;
         got.saturated  = rsp_saturated;
         stiffness_check.check_result(got);
      end
   end

   // Ready is only updated at the falling edge. During a hold-off it stays low
   // for a counted number of cycles while the sender keeps pushing triangles.
   always @(negedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_ready      <= 1'b0;
      end else if (quiet_phase) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 19);
      end
   end

   // Presents one triangle and holds it until a request beat takes it; the
   // expectation is recorded at the same edge the beat is accepted. Valid is
   // dropped only for idle cycles, so consecutive triangles follow without a gap.
   task automatic send_triangle(logic [15:0] tag, logic signed [31:0] vx [3],
                                logic signed [31:0] vy [3], logic [31:0] lambda);
      if (!quiet_phase) begin
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_element_tag  <= tag;
      req_x0 <= vx[0]; req_y0 <= vy[0];
      req_x1 <= vx[1]; req_y1 <= vy[1];
      req_x2 <= vx[2]; req_y2 <= vy[2];
      req_conductivity <= lambda;
      do @(posedge clock); while (!req_ready);
      stiffness_check.note_triangle(tag, vx, vy, lambda);
      triangles_sent++;
      @(negedge clock);
   endtask

   // A coordinate drawn from one of a few magnitude classes so that ordinary,
   // nearly flat and extreme triangles all appear.
   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $signed(32'($urandom_range(65535 * 64))) - (32 * 65536);
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(7)
                                           : 32'h8000_0000 + $urandom_range(7);
         default: return $signed(32'($urandom_range(4095)) << 12) - 32'sh0080_0000;
      endcase
   endfunction

   initial begin
      logic signed [31:0] vx [3];
      logic signed [31:0] vy [3];
      logic [31:0]        lambda;
      int                 kind;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed triangles: unit right triangle, both windings, degenerate
      // cases (collinear and coincident points), zero and full conductivity,
      // extreme coordinates that force the entries to clip.
      send_triangle(16'h0000, '{0, 32'h10000, 0}, '{0, 0, 32'h10000}, 32'h10000);
      send_triangle(16'hFFFF, '{0, 0, 32'h10000}, '{0, 32'h10000, 0}, 32'h10000);
      send_triangle(16'h0001, '{0, 32'h10000, 32'h20000}, '{0, 32'h10000, 32'h20000},
                    32'h10000);
      send_triangle(16'h0002, '{5, 5, 5}, '{-7, -7, -7}, 32'hFFFF_FFFF);
      send_triangle(16'h0003, '{0, 32'h10000, 0}, '{0, 0, 32'h10000}, 32'h0);
      send_triangle(16'h0004, '{0, 32'h10000, 0}, '{0, 0, 32'h10000}, 32'hFFFF_FFFF);
      send_triangle(16'h8000, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
                    '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 32'hFFFF_FFFF);
      send_triangle(16'h5555, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0001}, 32'hFFFF_FFFF);
      send_triangle(16'hAAAA, '{0, 1, 0}, '{0, 0, 1}, 32'h0000_0001);
      send_triangle(16'h1234, '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFE},
                    '{0, 1, 0}, 32'h8000_0000);
      send_triangle(16'h4321, '{-3, 4, 1}, '{2, -9, 8}, 32'h0003_0000);

      // Pipeline fill: the receiver stalls for a long counted stretch while
      // the sender keeps offering triangles without gaps.
      quiet_phase    = 1'b1;
      holdoff_cycles = 4 * PIPE_LATENCY;
      for (int n = 0; n < 60; n++) begin
         foreach (vx[i]) begin vx[i] = pick_coord(); vy[i] = pick_coord(); end
         send_triangle(16'($urandom()), vx, vy, $urandom());
      end

      // Random triangles; a window around the middle runs with no idling.
      for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
         quiet_phase = (n >= 700 && n < 1000);
         kind = $urandom_range(9);
         foreach (vx[i]) begin vx[i] = pick_coord(); vy[i] = pick_coord(); end
         if (kind == 0) begin
            vx[2] = vx[1]; vy[2] = vy[1];
         end else if (kind == 1) begin
            vx[1] = vx[0] + 32'sh1_0000; vy[1] = vy[0];
            vx[2] = vx[0] + 32'sh2_0000; vy[2] = vy[0];
         end
         lambda = (kind == 2) ? 32'h0 : (kind == 3) ? 32'hFFFF_FFFF : $urandom();
         send_triangle(16'($urandom()), vx, vy, lambda);
      end
      req_valid   <= 1'b0;
      quiet_phase = 1'b0;

      while (stiffness_check.pending.size() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Sent %0d triangles, checked %0d responses (%0d degenerate, %0d clipped).",
               triangles_sent, stiffness_check.checked,
               stiffness_check.degenerate_seen, stiffness_check.saturated_seen);
      $display("Mismatching responses: %0d.", stiffness_check.mismatches);
      if (stiffness_check.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
